FILE: rtl/core/gbn_pkg.sv
// Shared constants and types for the go-back-n sender.
// Used by the sender top level, its port checker and the testbench; depends on nothing else.
package gbn_pkg;

	localparam int WINDOW = 7;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	localparam int SEQ_W = 8;
	localparam int IDX_W = 16;
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [IDX_W-1:0] PACKET_TOTAL_RST = 16'd0;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PACKET_TOTAL = 1'b0,
		REG_TIMEOUT_TICKS = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_RESEND,
		ST_FILL,
		ST_TERM
	} state_t;

	// Bookkeeping for one outgoing packet.
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic resend;
		logic term;
		logic last;
	} send_t;

endpackage

FILE: rtl/core/gbn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instantiated by the sender for its send-time store.
module gbn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 7
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/go_back_n_sender.sv
// Go-back-n sender control: window bookkeeping, timeout resends, window fill, terminator.
// Depends on gbn_pkg and on gbn_ram, which keeps the send tick of each window slot.
//
//   channel  direction  signals                                   payload
//   in       sink       in_valid / in_ready                       action, ack_number
//   out      source     out_valid / out_ready                     send_number, packet_index,
//                                                                 is_resend, is_terminator, last
//   cfg      sink       cfg_valid / cfg_ready                     cfg_index, cfg_data
//
// One input item passes through accept, RAM read, age check and fill check, then sends one
// packet per cycle while the output accepts; the send-time RAM read port and the one-send-
// per-cycle walk over the window set that order. An output stall holds the walk in place.
// Reset clears the window, tick counter and finished flag at once; the RAM needs no clearing,
// since only reads of outstanding packets' slots are ever used. Configuration is always ready.
module go_back_n_sender (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic action,
	input  logic [gbn_pkg::SEQ_W-1:0] ack_number,
	output logic out_valid,
	input  logic out_ready,
	output logic [gbn_pkg::SEQ_W-1:0] send_number,
	output logic [gbn_pkg::IDX_W-1:0] packet_index,
	output logic is_resend,
	output logic is_terminator,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gbn_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0] total_q;
	logic [TICK_W-1:0] timeout_q;
	logic [IDX_W-1:0] base_q, next_q, cur_idx_q;
	logic [SLOT_W-1:0] base_slot_q, next_slot_q, cur_slot_q;
	logic [TICK_W-1:0] tick_q;
	logic finished_q;

	logic out_valid_q;
	send_t out_q;

	logic [TICK_W-1:0] ram_rdata;
	logic ram_we;
	logic [SLOT_W-1:0] ram_waddr;

	logic out_free, emit;
	send_t emit_pkt;
	logic [CNT_W-1:0] outstanding;
	logic fill_cond, term_cond, timed_out, ack_hit;
	logic [IDX_W-1:0] next_inc, cur_inc;
	logic [TICK_W-1:0] age;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(WINDOW - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	gbn_ram #(
		.WIDTH(TICK_W),
		.DEPTH(WINDOW)
	) u_send_time (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(tick_q),
		.raddr(base_slot_q),
		.rdata(ram_rdata)
	);

	assign out_free = !out_valid_q || out_ready;
	assign outstanding = CNT_W'(next_q - base_q);
	assign next_inc = next_q + 1'b1;
	assign cur_inc = cur_idx_q + 1'b1;
	assign fill_cond = (next_q < total_q) && (outstanding < CNT_W'(WINDOW));
	assign term_cond = (base_q == next_q) && (next_q >= total_q);
	assign age = tick_q - ram_rdata;
	assign timed_out = (base_q < next_q) && (age >= timeout_q);
	assign ack_hit = action && (base_q < next_q) && (ack_number == base_q[SEQ_W-1:0]);

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !finished_q) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_CHECK;
			ST_CHECK: state_d = timed_out ? ST_RESEND : ST_FILL;
			ST_RESEND: begin
				if (out_free && cur_inc == next_q) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!fill_cond) begin
					state_d = term_cond ? ST_TERM : ST_IDLE;
				end
			end
			ST_TERM: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		emit_pkt = '0;
		ram_we = 1'b0;
		ram_waddr = cur_slot_q;
		unique case (state_q)
			ST_RESEND: begin
				emit = out_free;
				emit_pkt.idx = cur_idx_q;
				emit_pkt.resend = 1'b1;
				// No terminator can follow a resend, since packets are still outstanding.
				emit_pkt.last = (cur_inc == next_q) && !fill_cond;
				ram_we = out_free;
				ram_waddr = cur_slot_q;
			end
			ST_FILL: begin
				emit = out_free && fill_cond;
				emit_pkt.idx = next_q;
				emit_pkt.last = !((next_inc < total_q) &&
					((outstanding + 1'b1) < CNT_W'(WINDOW)));
				ram_we = out_free && fill_cond;
				ram_waddr = next_slot_q;
			end
			ST_TERM: begin
				emit = out_free;
				emit_pkt.idx = next_q;
				emit_pkt.term = 1'b1;
				emit_pkt.last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= PACKET_TOTAL_RST;
			timeout_q <= TIMEOUT_RST;
			base_q <= '0;
			next_q <= '0;
			base_slot_q <= '0;
			next_slot_q <= '0;
			tick_q <= '0;
			finished_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_PACKET_TOTAL: total_q <= cfg_data;
					REG_TIMEOUT_TICKS: timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && in_valid && !finished_q) begin
				if (!action) begin
					tick_q <= tick_q + 1'b1;
				end else if (ack_hit) begin
					base_q <= base_q + 1'b1;
					base_slot_q <= slot_inc(base_slot_q);
				end
			end
			if (state_q == ST_FILL && emit) begin
				next_q <= next_inc;
				next_slot_q <= slot_inc(next_slot_q);
			end
			if (state_q == ST_TERM && emit) begin
				finished_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk pointer and output payload carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			cur_idx_q <= base_q;
			cur_slot_q <= base_slot_q;
		end else if (state_q == ST_RESEND && out_free) begin
			cur_idx_q <= cur_inc;
			cur_slot_q <= slot_inc(cur_slot_q);
		end
		if (emit) begin
			out_q <= emit_pkt;
		end
	end

	assign out_valid = out_valid_q;
	assign send_number = out_q.idx[SEQ_W-1:0];
	assign packet_index = out_q.idx;
	assign is_resend = out_q.resend;
	assign is_terminator = out_q.term;
	assign last = out_q.last;

endmodule

FILE: rtl/core/gbn_checker.sv
// Port-level checks for the go-back-n sender, bound to its top level.
// Depends on gbn_pkg for field widths.
module gbn_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [gbn_pkg::SEQ_W-1:0] send_number,
	input logic [gbn_pkg::IDX_W-1:0] packet_index,
	input logic is_resend,
	input logic is_terminator,
	input logic last
);
	import gbn_pkg::*;

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packet_index) &&
		$stable(is_resend) && $stable(is_terminator) && $stable(last))
		else $error("stalled output changed");

	// The sequence number is the low byte of the packet index.
	a_seq_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> send_number == packet_index[SEQ_W-1:0])
		else $error("send_number does not match packet_index");

	// The terminator closes its input's burst and is never a resend.
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_terminator |-> last && !is_resend)
		else $error("terminator not last or flagged as resend");

	// Nothing follows the terminator transfer.
	a_term_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && is_terminator |=> !out_valid)
		else $error("output after terminator");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (.*);

FILE: tb/sv/tb_go_back_n_sender.sv
// Self-checking testbench for the go-back-n sender: directed table, random mix, tick run.
// Predicts every send from its own window model and compares each output transfer in order.
// Depends on gbn_pkg and the go_back_n_sender RTL.
module tb_go_back_n_sender;
	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_ACK = 1'b1;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [IDX_W-1:0] idx;
		logic resend;
		logic term;
		logic last;
	} send_rec_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_reg_t reg_sel;
		logic [CFG_DATA_W-1:0] data;
		logic act;
		logic [SEQ_W-1:0] ack;
		logic typed;
		logic [3:0] count;
		logic [IDX_W-1:0] first_idx;
		logic first_resend;
	} dir_row_t;

	// Rows with typed counts can be read straight off the window rules: the first tick fills
	// seven slots, a stale acknowledgement does nothing, and the fifth idle tick resends.
	localparam dir_row_t DIRECTED [22] = '{
		'{ROW_CFG,  REG_PACKET_TOTAL,  16'hFFFF, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'hFF, 1'b1, 4'd7, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h05, 1'b1, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h00, 1'b1, 4'd1, 16'd7, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h01, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h02, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h80, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h7F, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h03, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h00, 1'b1, 4'd7, 16'd3, 1'b1},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'hFF, 1'b1, 4'd0, 16'd0, 1'b0},
		'{ROW_CFG,  REG_TIMEOUT_TICKS, 16'h0000, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h55, 1'b1, 4'd7, 16'd3, 1'b1},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h03, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_CFG,  REG_TIMEOUT_TICKS, 16'h0001, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h04, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_CFG,  REG_TIMEOUT_TICKS, 16'hFFFF, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_TICK, 8'hAA, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_ITEM, REG_PACKET_TOTAL,  16'h0000, ACT_ACK,  8'h05, 1'b0, 4'd0, 16'd0, 1'b0},
		'{ROW_CFG,  REG_TIMEOUT_TICKS, 16'h0003, ACT_TICK, 8'h00, 1'b0, 4'd0, 16'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [SEQ_W-1:0] ack_number = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SEQ_W-1:0] send_number;
	logic [IDX_W-1:0] packet_index;
	logic is_resend;
	logic is_terminator;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Window model state.
	logic [IDX_W-1:0] total_cfg = PACKET_TOTAL_RST;
	logic [TICK_W-1:0] timeout_cfg = TIMEOUT_RST;
	int base_idx = 0;
	int next_idx = 0;
	logic [TICK_W-1:0] tick_cnt = '0;
	logic [TICK_W-1:0] send_tick [WINDOW];
	bit run_done = 1'b0;

	send_rec_t pending_sends [$];
	send_rec_t head_send;
	int err_count = 0;
	int rx_idle_pct = 0;
	int rx_hold_len = 0;
	bit finish_ok = 1'b0;

	always #2 clk = ~clk;

	go_back_n_sender u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.ack_number(ack_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.send_number(send_number),
		.packet_index(packet_index),
		.is_resend(is_resend),
		.is_terminator(is_terminator),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	task automatic report_mismatch(string what);
		err_count++;
		if (err_count <= 50)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	function automatic send_rec_t make_send(int index, logic resend, logic term);
		send_rec_t rec;
		rec.seq = SEQ_W'(index);
		rec.idx = IDX_W'(index);
		rec.resend = resend;
		rec.term = term;
		rec.last = 1'b0;
		return rec;
	endfunction

	// Advances the window model by one accepted input and queues the sends it causes.
	function automatic int compute_sends(logic act, logic [SEQ_W-1:0] ack);
		send_rec_t recs [8];
		int n;
		int i;
		logic [TICK_W-1:0] age;
		n = 0;
		if (run_done)
			return 0;
		if (act == ACT_ACK) begin
			if (base_idx < next_idx && ack == SEQ_W'(base_idx))
				base_idx++;
		end else begin
			tick_cnt++;
		end
		if (base_idx < next_idx) begin
			// Ages wrap with the 16-bit tick counter.
			age = tick_cnt - send_tick[base_idx % WINDOW];
			if (age >= timeout_cfg) begin
				for (i = base_idx; i < next_idx; i++) begin
					send_tick[i % WINDOW] = tick_cnt;
					recs[n] = make_send(i, 1'b1, 1'b0);
					n++;
				end
			end
		end
		while (next_idx < total_cfg && next_idx - base_idx < WINDOW) begin
			send_tick[next_idx % WINDOW] = tick_cnt;
			recs[n] = make_send(next_idx, 1'b0, 1'b0);
			n++;
			next_idx++;
		end
		if (base_idx == next_idx && next_idx >= total_cfg) begin
			recs[n] = make_send(next_idx, 1'b0, 1'b1);
			n++;
			run_done = 1'b1;
		end
		for (i = 0; i < n; i++) begin
			recs[i].last = (i == n - 1);
			pending_sends.push_back(recs[i]);
		end
		if (n > 0)
			head_send = recs[0];
		return n;
	endfunction

	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sends.size() != 0)
			@(posedge clk);
		// An input that causes no send may still be in flight.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] data);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (which)
			REG_PACKET_TOTAL: total_cfg = data;
			REG_TIMEOUT_TICKS: timeout_cfg = data;
			default: ;
		endcase
	endtask

	task automatic offer_item(logic act, logic [SEQ_W-1:0] ack, output int n_sends);
		in_valid <= 1'b1;
		action <= act;
		ack_number <= ack;
		do @(posedge clk); while (!in_ready);
		n_sends = compute_sends(act, ack);
	endtask

	// Mostly acknowledgements that slide the window; the rest ticks and stray acknowledgements.
	task automatic pick_item(output logic act, output logic [SEQ_W-1:0] ack);
		int r;
		r = $urandom_range(99);
		ack = SEQ_W'($urandom);
		act = ACT_ACK;
		if (r < 60 && base_idx < next_idx)
			ack = SEQ_W'(base_idx);
		else if (r < 85)
			act = ACT_TICK;
		// Keep the last packet outstanding so the terminator waits for the closing phase.
		if (!finish_ok && act == ACT_ACK && ack == SEQ_W'(base_idx)
				&& next_idx - base_idx == 1 && next_idx >= total_cfg)
			act = ACT_TICK;
	endtask

	task automatic run_random(int count, int tx_idle_pct, int hold_at);
		logic act;
		logic [SEQ_W-1:0] ack;
		int n;
		for (int k = 0; k < count; k++) begin
			if (k == hold_at)
				rx_hold_len = 300;
			pick_item(act, ack);
			offer_item(act, ack, n);
			if ($urandom_range(99) < 3) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_sends.size() != 0)
					@(posedge clk);
			end else if ($urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
			end
		end
	endtask

	// Output side: check each transfer, then choose the next ready value.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_sends.size() == 0) begin
					report_mismatch("send with nothing expected");
				end else begin
					head_check: begin
						send_rec_t want;
						want = pending_sends.pop_front();
						if (send_number !== want.seq)
							report_mismatch($sformatf("send_number %0d, expected %0d",
								send_number, want.seq));
						if (packet_index !== want.idx)
							report_mismatch($sformatf("packet_index %0d, expected %0d",
								packet_index, want.idx));
						if (is_resend !== want.resend)
							report_mismatch($sformatf("is_resend %b at index %0d",
								is_resend, want.idx));
						if (is_terminator !== want.term)
							report_mismatch($sformatf("is_terminator %b at index %0d",
								is_terminator, want.idx));
						if (last !== want.last)
							report_mismatch($sformatf("last %b at index %0d", last, want.idx));
					end
				end
			end
			if (rx_hold_len > 0) begin
				out_ready <= 1'b0;
				rx_hold_len--;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		int n;
		logic act;
		logic [SEQ_W-1:0] ack;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			if (DIRECTED[r].kind == ROW_CFG) begin
				write_reg(DIRECTED[r].reg_sel, DIRECTED[r].data);
			end else begin
				offer_item(DIRECTED[r].act, DIRECTED[r].ack, n);
				if (DIRECTED[r].typed && (n != DIRECTED[r].count || (n > 0
						&& (head_send.idx != DIRECTED[r].first_idx
						|| head_send.resend != DIRECTED[r].first_resend))))
					report_mismatch($sformatf("table row %0d: %0d sends predicted", r, n));
			end
		end

		// Receiver mostly stalled, with one long hold-off while input keeps coming.
		rx_idle_pct = 73;
		run_random(130, 21, 20);

		// Sender mostly idle, with the packet total just ahead so the fill stops short.
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'($urandom_range(1, 12)));
		write_reg(REG_PACKET_TOTAL, CFG_DATA_W'(next_idx + $urandom_range(1, 3)));
		rx_idle_pct = 21;
		run_random(130, 73, -1);

		write_reg(REG_PACKET_TOTAL, 16'hFFFF);
		write_reg(REG_TIMEOUT_TICKS, 16'd2);
		rx_idle_pct = 0;
		run_random(130, 0, -1);

		// Maximum timeout: a run of ticks brings no packet due for a resend.
		write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
		repeat (12) offer_item(ACT_TICK, SEQ_W'($urandom), n);

		// Drop the total to zero so the window drains and the terminator goes out.
		write_reg(REG_TIMEOUT_TICKS, 16'd3);
		write_reg(REG_PACKET_TOTAL, 16'd0);
		finish_ok = 1'b1;
		rx_idle_pct = 30;
		while (!run_done) begin
			pick_item(act, ack);
			offer_item(act, ack, n);
		end
		// Once finished, every input is dropped without a send.
		repeat (6) begin
			pick_item(act, ack);
			offer_item(act, ack, n);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sends.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/gbn_pkg.sv
rtl/core/gbn_ram.sv
rtl/core/go_back_n_sender.sv
rtl/core/gbn_checker.sv
tb/sv/tb_go_back_n_sender.sv
